// ----- rtl/ajb_pkg.sv -----
// Shared types, codes and constants of the adaptive jitter buffer.
// Used by every module under rtl except ajb_ram; depends on nothing else.
package ajb_pkg;

  // Store depth default and field widths
  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int DEPTH_W   = 6;
  localparam int RATE_W    = 18;
  localparam int TS_W      = 32;
  localparam int NS_W      = 64;
  localparam int FR_W      = 13;
  localparam int TAG_W     = 8;
  localparam int CNT_W     = 32;
  localparam int STAT_W    = 3;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = RATE_W;

  // frames * 1e9 fits 43 bits; target * duration fits 49 bits
  localparam int NUM_W = 43;
  localparam int DLY_W = NUM_W + DEPTH_W;
  localparam int ENT_W = TS_W + NS_W + FR_W + TAG_W;

  localparam logic [29:0] NS_PER_S = 30'd1000000000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DEPTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd2;

  // Reset values
  localparam logic [DEPTH_W-1:0] MIN_DEPTH_RST = 6'd2;
  localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = 6'd8;
  localparam logic [RATE_W-1:0]  RATE_RST      = 18'd48000;
  localparam logic [DEPTH_W-1:0] TARGET_RST    = 6'((2 + 8) / 2);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_POLL    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_FLUSH   = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DROPPED   = 3'd1,
    ST_READY     = 3'd2,
    ST_NOT_DUE   = 3'd3,
    ST_UNDERRUN  = 3'd4,
    ST_RELEASED  = 3'd5,
    ST_REL_EMPTY = 3'd6,
    ST_FLUSHED   = 3'd7
  } stat_e;

  // Controller to datapath commands
  typedef struct packed {
    logic cap;
    logic ins_rd;
    logic ins_shift;
    logic ins_put;
    logic drop;
    logic poll_rd;
    logic mul;
    logic div_step;
    logic dly;
    logic add;
    logic pcmp;
    logic underrun;
    logic release_hd;
    logic rel_empty;
    logic flush;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic k_one;
    logic rd_ge;
    logic div_done;
  } sts_t;

endpackage

// ----- rtl/adaptive_jitter_buffer.sv -----
// Top level of the adaptive jitter buffer: controller plus datapath.
// Depends on ajb_pkg, ajb_ctrl, ajb_datapath (which holds ajb_ram).
//
//   channel   direction  handshake              payload
//   input     in         in_valid_i/in_stall_o  op, packet fields, now_ns
//   output    out        out_valid_o/out_stall_i status, head, levels, counters
//   config    in         cfg_we_i               cfg_index_i, cfg_wdata_i
//
// One word at a time. Flush, release, a full insert and an empty poll go straight
// from dispatch to the output step; a non-empty insert walks back from the tail,
// comparing entries, and a non-empty poll runs the 43-step bit-serial divider.
// A result waits in the output register while the next word is taken.
// Reset clears the fill count and counters; store contents are not cleared.
module adaptive_jitter_buffer #(
  parameter int QUEUE_DEPTH = ajb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ajb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ajb_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ajb_pkg::OP_W-1:0]      op_i,
  input  logic [ajb_pkg::TS_W-1:0]      pkt_timestamp_i,
  input  logic [ajb_pkg::NS_W-1:0]      arrival_ns_i,
  input  logic [ajb_pkg::FR_W-1:0]      frame_count_i,
  input  logic [ajb_pkg::TAG_W-1:0]     payload_tag_i,
  input  logic [ajb_pkg::NS_W-1:0]      now_ns_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ajb_pkg::STAT_W-1:0]    status_o,
  output logic [ajb_pkg::TS_W-1:0]      head_timestamp_o,
  output logic [ajb_pkg::FR_W-1:0]      head_frames_o,
  output logic [ajb_pkg::TAG_W-1:0]     head_tag_o,
  output logic [ajb_pkg::DEPTH_W-1:0]   fill_level_o,
  output logic [ajb_pkg::DEPTH_W-1:0]   target_level_o,
  output logic [ajb_pkg::CNT_W-1:0]     underrun_total_o,
  output logic [ajb_pkg::CNT_W-1:0]     overrun_total_o
);
  import ajb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ajb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ajb_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .op_i             (op_i),
    .pkt_timestamp_i  (pkt_timestamp_i),
    .arrival_ns_i     (arrival_ns_i),
    .frame_count_i    (frame_count_i),
    .payload_tag_i    (payload_tag_i),
    .now_ns_i         (now_ns_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .status_o         (status_o),
    .head_timestamp_o (head_timestamp_o),
    .head_frames_o    (head_frames_o),
    .head_tag_o       (head_tag_o),
    .fill_level_o     (fill_level_o),
    .target_level_o   (target_level_o),
    .underrun_total_o (underrun_total_o),
    .overrun_total_o  (overrun_total_o)
  );

endmodule

// ----- rtl/ajb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ajb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ajb_datapath.sv -----
// Datapath: config registers, circular descriptor store, divider, delay math, result.
// Depends on ajb_pkg and ajb_ram.
module ajb_datapath #(
  parameter int QUEUE_DEPTH = ajb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ajb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ajb_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic [ajb_pkg::OP_W-1:0]      op_i,
  input  logic [ajb_pkg::TS_W-1:0]      pkt_timestamp_i,
  input  logic [ajb_pkg::NS_W-1:0]      arrival_ns_i,
  input  logic [ajb_pkg::FR_W-1:0]      frame_count_i,
  input  logic [ajb_pkg::TAG_W-1:0]     payload_tag_i,
  input  logic [ajb_pkg::NS_W-1:0]      now_ns_i,
  input  ajb_pkg::cmd_t                 cmd_i,
  output ajb_pkg::sts_t                 sts_o,
  output logic [ajb_pkg::STAT_W-1:0]    status_o,
  output logic [ajb_pkg::TS_W-1:0]      head_timestamp_o,
  output logic [ajb_pkg::FR_W-1:0]      head_frames_o,
  output logic [ajb_pkg::TAG_W-1:0]     head_tag_o,
  output logic [ajb_pkg::DEPTH_W-1:0]   fill_level_o,
  output logic [ajb_pkg::DEPTH_W-1:0]   target_level_o,
  output logic [ajb_pkg::CNT_W-1:0]     underrun_total_o,
  output logic [ajb_pkg::CNT_W-1:0]     overrun_total_o
);
  import ajb_pkg::*;

  localparam int AW  = $clog2(QUEUE_DEPTH);
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int CW  = (FW > DEPTH_W) ? FW : DEPTH_W;
  localparam int DCW = $clog2(NUM_W + 1);

  // Config registers
  logic [DEPTH_W-1:0] min_q, max_q;
  logic [RATE_W-1:0]  rate_q;

  // Queue state
  logic [AW-1:0]      head_q;
  logic [FW-1:0]      fill_q, k_q;
  logic [DEPTH_W-1:0] target_q;
  logic [CNT_W-1:0]   under_q, over_q;

  // Captured word
  op_e                op_q;
  logic [TS_W-1:0]    ts_q;
  logic [NS_W-1:0]    arr_q, now_q;
  logic [FR_W-1:0]    fr_q;
  logic [TAG_W-1:0]   tag_q;

  // Head copy and due-time math
  logic [TS_W-1:0]    hd_ts_q;
  logic [NS_W-1:0]    hd_arr_q;
  logic [FR_W-1:0]    hd_fr_q;
  logic [TAG_W-1:0]   hd_tag_q;
  logic [NUM_W-1:0]   quo_q;
  logic [RATE_W-1:0]  rem_q;
  logic [DCW-1:0]     dcnt_q;
  logic [NS_W-1:0]    dly_q, when_q;
  logic               ovf_q;
  stat_e              stat_q;

  // Output registers
  logic [STAT_W-1:0]  out_stat_q;
  logic [TS_W-1:0]    out_ts_q;
  logic [FR_W-1:0]    out_fr_q;
  logic [TAG_W-1:0]   out_tag_q;
  logic [DEPTH_W-1:0] out_fill_q, out_tgt_q;
  logic [CNT_W-1:0]   out_under_q, out_over_q;

  // RAM
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ENT_W-1:0]   ram_wdata, ram_rdata;
  logic [TS_W-1:0]    rd_ts;
  logic [NS_W-1:0]    rd_arr;
  logic [FR_W-1:0]    rd_fr;
  logic [TAG_W-1:0]   rd_tag;

  logic [FW-1:0]      k_m1;
  logic [NUM_W-1:0]   num;
  logic [RATE_W:0]    rem_sh;
  logic [DLY_W-1:0]   prod;
  logic [NS_W:0]      sum;
  logic [DEPTH_W+1:0] d8, t1, t2, t3, u_tgt;
  logic               u_clr;

  // Offset from head to physical slot, with one wrap
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, hd} + {1'b0, off};
    if (s >= (AW+1)'(QUEUE_DEPTH)) begin
      s = s - (AW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign {rd_ts, rd_arr, rd_fr, rd_tag} = ram_rdata;
  assign k_m1 = k_q - FW'(1);

  // Store port steering
  always_comb begin
    ram_re    = cmd_i.ins_rd | cmd_i.poll_rd;
    ram_raddr = cmd_i.poll_rd ? head_q : phys(head_q, k_m1[AW-1:0]);
    ram_we    = cmd_i.ins_shift | cmd_i.ins_put;
    ram_waddr = phys(head_q, k_q[AW-1:0]);
    ram_wdata = cmd_i.ins_put ? {ts_q, arr_q, fr_q, tag_q} : ram_rdata;
  end

  ajb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Status toward the controller
  always_comb begin
    sts_o.op       = op_q;
    sts_o.full     = (CW'(fill_q) >= CW'(max_q)) || (fill_q >= FW'(QUEUE_DEPTH));
    sts_o.empty    = (fill_q == '0);
    sts_o.k_one    = (k_q == FW'(1));
    sts_o.rd_ge    = (rd_ts >= ts_q);
    sts_o.div_done = (dcnt_q == '0);
  end

  // Target adaptation after an insert, d8 is the new fill
  always_comb begin
    d8    = (DEPTH_W+2)'(fill_q) + 1'b1;
    t1    = {2'b00, target_q};
    if ((d8 + 1'b1 >= {2'b00, max_q}) && (t1 < {2'b00, max_q})) begin
      t1 = t1 + 1'b1;
    end
    t2    = t1;
    u_clr = 1'b0;
    if ((under_q != '0) && (t2 < {2'b00, max_q})) begin
      t2    = t2 + 1'b1;
      u_clr = 1'b1;
    end
    t3 = t2;
    if ((d8 > t2 + 2'd2) && (u_clr || under_q == '0) && (t2 > {2'b00, min_q})) begin
      t3 = t2 - 1'b1;
    end
    u_tgt = t3;
  end

  // Due-time arithmetic pieces
  assign num    = NUM_W'(rd_fr) * NUM_W'(NS_PER_S);
  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign prod   = DLY_W'(target_q) * DLY_W'(quo_q);
  assign sum    = {1'b0, hd_arr_q} + {1'b0, dly_q};

  // Config, queue state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= MIN_DEPTH_RST;
      max_q    <= MAX_DEPTH_RST;
      rate_q   <= RATE_RST;
      head_q   <= '0;
      fill_q   <= '0;
      k_q      <= '0;
      target_q <= TARGET_RST;
      under_q  <= '0;
      over_q   <= '0;
      dcnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MIN_DEPTH:   min_q  <= cfg_wdata_i[DEPTH_W-1:0];
          CFG_MAX_DEPTH:   max_q  <= cfg_wdata_i[DEPTH_W-1:0];
          CFG_SAMPLE_RATE: rate_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.cap) begin
        k_q <= fill_q;
      end
      if (cmd_i.ins_shift) begin
        k_q <= k_m1;
      end
      if (cmd_i.ins_put) begin
        fill_q   <= fill_q + FW'(1);
        target_q <= u_tgt[DEPTH_W-1:0];
        if (u_clr) begin
          under_q <= '0;
        end
      end
      if (cmd_i.drop && over_q != '1) begin
        over_q <= over_q + 1'b1;
      end
      if (cmd_i.underrun && under_q != '1) begin
        under_q <= under_q + 1'b1;
      end
      if (cmd_i.release_hd) begin
        head_q <= phys(head_q, AW'(1));
        fill_q <= fill_q - FW'(1);
      end
      if (cmd_i.flush) begin
        fill_q  <= '0;
        under_q <= '0;
        over_q  <= '0;
      end
      if (cmd_i.mul) begin
        dcnt_q <= DCW'(NUM_W);
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q - 1'b1;
      end
    end
  end

  // Captured word, head copy, divider and delay registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q  <= op_e'(op_i);
      ts_q  <= pkt_timestamp_i;
      arr_q <= arrival_ns_i;
      fr_q  <= frame_count_i;
      tag_q <= payload_tag_i;
      now_q <= now_ns_i;
    end
    if (cmd_i.mul) begin
      hd_ts_q  <= rd_ts;
      hd_arr_q <= rd_arr;
      hd_fr_q  <= rd_fr;
      hd_tag_q <= rd_tag;
      quo_q    <= num;
      rem_q    <= '0;
    end
    // Restoring divide, one quotient bit a cycle
    if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, rate_q}) begin
        rem_q <= RATE_W'(rem_sh - {1'b0, rate_q});
        quo_q <= {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[RATE_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b0};
      end
    end
    // Zero rate means an all-ones duration
    if (cmd_i.dly) begin
      ovf_q <= 1'b0;
      if (rate_q == '0) begin
        if (target_q == '0) begin
          dly_q <= '0;
        end else if (target_q == DEPTH_W'(1)) begin
          dly_q <= '1;
        end else begin
          dly_q <= '0;
          ovf_q <= 1'b1;
        end
      end else begin
        dly_q <= NS_W'(prod);
      end
    end
    if (cmd_i.add) begin
      when_q <= sum[NS_W-1:0];
      ovf_q  <= ovf_q | sum[NS_W];
    end
    // Result code
    if (cmd_i.pcmp) begin
      stat_q <= (!ovf_q && now_q >= when_q) ? ST_READY : ST_NOT_DUE;
    end
    if (cmd_i.ins_put)    stat_q <= ST_INSERTED;
    if (cmd_i.drop)       stat_q <= ST_DROPPED;
    if (cmd_i.underrun)   stat_q <= ST_UNDERRUN;
    if (cmd_i.release_hd) stat_q <= ST_RELEASED;
    if (cmd_i.rel_empty)  stat_q <= ST_REL_EMPTY;
    if (cmd_i.flush)      stat_q <= ST_FLUSHED;
    // Output word
    if (cmd_i.out_load) begin
      out_stat_q  <= stat_q;
      out_ts_q    <= (stat_q == ST_READY) ? hd_ts_q : '0;
      out_fr_q    <= (stat_q == ST_READY) ? hd_fr_q : '0;
      out_tag_q   <= (stat_q == ST_READY) ? hd_tag_q : '0;
      out_fill_q  <= DEPTH_W'(fill_q);
      out_tgt_q   <= target_q;
      out_under_q <= under_q;
      out_over_q  <= over_q;
    end
  end

  assign status_o         = out_stat_q;
  assign head_timestamp_o = out_ts_q;
  assign head_frames_o    = out_fr_q;
  assign head_tag_o       = out_tag_q;
  assign fill_level_o     = out_fill_q;
  assign target_level_o   = out_tgt_q;
  assign underrun_total_o = out_under_q;
  assign overrun_total_o  = out_over_q;

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(QUEUE_DEPTH))
    else $error("fill exceeds store depth");

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |=> (fill_q == '0 && under_q == '0 && over_q == '0))
    else $error("flush did not clear state");

  a_target_insert_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.ins_put |=> $stable(target_q))
    else $error("target moved outside an insert");

  a_div_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> dcnt_q != '0)
    else $error("divider stepped past its last bit");

endmodule

// ----- rtl/ajb_ctrl.sv -----
// Controller FSM: sequences insert walk, poll math, release, flush and output handoff.
// Depends on ajb_pkg.
module ajb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  ajb_pkg::sts_t sts_i,
  output ajb_pkg::cmd_t cmd_o
);
  import ajb_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_DISP = 12'b000000000010,
    S_RD   = 12'b000000000100,
    S_CMP  = 12'b000000001000,
    S_PUT  = 12'b000000010000,
    S_PRD  = 12'b000000100000,
    S_MUL  = 12'b000001000000,
    S_DIV  = 12'b000010000000,
    S_DLY  = 12'b000100000000,
    S_ADD  = 12'b001000000000,
    S_PCMP = 12'b010000000000,
    S_FIN  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.op)
          OP_INSERT: begin
            if (sts_i.full) begin
              cmd_o.drop = 1'b1;
              state_d    = S_FIN;
            end else if (sts_i.empty) begin
              state_d = S_PUT;
            end else begin
              state_d = S_RD;
            end
          end
          OP_POLL: begin
            if (sts_i.empty) begin
              cmd_o.underrun = 1'b1;
              state_d        = S_FIN;
            end else begin
              state_d = S_PRD;
            end
          end
          OP_RELEASE: begin
            if (sts_i.empty) begin
              cmd_o.rel_empty = 1'b1;
            end else begin
              cmd_o.release_hd = 1'b1;
            end
            state_d = S_FIN;
          end
          default: begin
            cmd_o.flush = 1'b1;
            state_d     = S_FIN;
          end
        endcase
      end
      // Walk back from the tail, moving larger or equal stamps up one slot
      S_RD: begin
        cmd_o.ins_rd = 1'b1;
        state_d      = S_CMP;
      end
      S_CMP: begin
        if (sts_i.rd_ge) begin
          cmd_o.ins_shift = 1'b1;
          state_d         = sts_i.k_one ? S_PUT : S_RD;
        end else begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        cmd_o.ins_put = 1'b1;
        state_d       = S_FIN;
      end
      S_PRD: begin
        cmd_o.poll_rd = 1'b1;
        state_d       = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_DLY;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_DLY: begin
        cmd_o.dly = 1'b1;
        state_d   = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_PCMP;
      end
      S_PCMP: begin
        cmd_o.pcmp = 1'b1;
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // Checks
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && out_valid_q) |-> !out_stall_i)
    else $error("pending result overwritten");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result word dropped");

endmodule

// ----- verif/adaptive_jitter_buffer_test.sv -----
// Self-checking testbench for adaptive_jitter_buffer: random and directed words,
// checked against a built-in model. Depends on ajb_pkg and the RTL under rtl/.
module adaptive_jitter_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ajb_pkg::*;

  localparam int QD        = 32;
  localparam int CYCLE_CAP = 2000000;
  localparam int SETTLE    = 120;

  typedef struct {
    op_e              op;
    logic [TS_W-1:0]  ts;
    logic [NS_W-1:0]  arrival;
    logic [FR_W-1:0]  frames;
    logic [TAG_W-1:0] tag;
    logic [NS_W-1:0]  now;
  } pkt_word_t;

  typedef struct {
    stat_e              status;
    logic [TS_W-1:0]    hts;
    logic [FR_W-1:0]    hfr;
    logic [TAG_W-1:0]   htag;
    logic [DEPTH_W-1:0] fill;
    logic [DEPTH_W-1:0] target;
    logic [CNT_W-1:0]   und;
    logic [CNT_W-1:0]   ovr;
  } buf_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [OP_W-1:0] op_i = '0;
  logic [TS_W-1:0] pkt_timestamp_i = '0;
  logic [NS_W-1:0] arrival_ns_i = '0;
  logic [FR_W-1:0] frame_count_i = '0;
  logic [TAG_W-1:0] payload_tag_i = '0;
  logic [NS_W-1:0] now_ns_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [STAT_W-1:0] status_o;
  logic [TS_W-1:0] head_timestamp_o;
  logic [FR_W-1:0] head_frames_o;
  logic [TAG_W-1:0] head_tag_o;
  logic [DEPTH_W-1:0] fill_level_o;
  logic [DEPTH_W-1:0] target_level_o;
  logic [CNT_W-1:0] underrun_total_o;
  logic [CNT_W-1:0] overrun_total_o;

  adaptive_jitter_buffer dut (.*);

  always #10 clk_i = ~clk_i;

  // Model state of the buffer
  logic [DEPTH_W-1:0] m_min = MIN_DEPTH_RST;
  logic [DEPTH_W-1:0] m_max = MAX_DEPTH_RST;
  logic [RATE_W-1:0]  m_rate = RATE_RST;
  logic [TS_W-1:0]    m_ts [QD];
  logic [NS_W-1:0]    m_arr [QD];
  logic [FR_W-1:0]    m_fr [QD];
  logic [TAG_W-1:0]   m_tag [QD];
  int                 m_fill = 0;
  int                 m_target = TARGET_RST;
  logic [CNT_W-1:0]   m_und = '0;
  logic [CNT_W-1:0]   m_ovr = '0;

  pkt_word_t   pending_words[$];
  buf_result_t awaited_results[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          word_taken = 1'b0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          send_mode = 0;
  int          stall_mode = 0;
  int          stall_timer = 0;

  // Head due check: arrival + target * (frames * 1e9 / rate) <= now, no wrap
  function automatic bit head_is_due(logic [NS_W-1:0] now);
    logic [127:0] num, dur, prod, sum;
    num = 128'(m_fr[0]) * 128'(64'd1000000000);
    dur = (m_rate != 0) ? num / 128'(m_rate) : 128'({NS_W{1'b1}});
    prod = dur * 128'(m_target);
    if (prod[127:64] != 0) return 1'b0;
    sum = 128'(m_arr[0]) + prod;
    if (sum[127:64] != 0) return 1'b0;
    return now >= sum[63:0];
  endfunction

  // Apply one accepted word to the model and queue its result
  task automatic buffer_step(pkt_word_t w);
    buf_result_t r;
    int cap, pos;
    r = '{status: ST_INSERTED, hts: '0, hfr: '0, htag: '0, fill: '0, target: '0,
          und: '0, ovr: '0};
    cap = (m_max < QD) ? int'(m_max) : QD;
    case (w.op)
      OP_INSERT: begin
        if (m_fill >= cap) begin
          if (m_ovr != '1) m_ovr++;
          r.status = ST_DROPPED;
        end else begin
          pos = 0;
          while (pos < m_fill && m_ts[pos] < w.ts) pos++;
          for (int k = m_fill; k > pos; k--) begin
            m_ts[k] = m_ts[k-1]; m_arr[k] = m_arr[k-1];
            m_fr[k] = m_fr[k-1]; m_tag[k] = m_tag[k-1];
          end
          m_ts[pos] = w.ts; m_arr[pos] = w.arrival;
          m_fr[pos] = w.frames; m_tag[pos] = w.tag;
          m_fill++;
          // target adaptation
          if (m_fill + 1 >= m_max && m_target < m_max) m_target++;
          if (m_und != 0 && m_target < m_max) begin
            m_target++;
            m_und = '0;
          end
          if (m_fill > m_target + 2 && m_und == 0 && m_target > m_min) m_target--;
          m_target &= 63;
          r.status = ST_INSERTED;
        end
      end
      OP_POLL: begin
        if (m_fill == 0) begin
          if (m_und != '1) m_und++;
          r.status = ST_UNDERRUN;
        end else if (head_is_due(w.now)) begin
          r.status = ST_READY;
          r.hts = m_ts[0]; r.hfr = m_fr[0]; r.htag = m_tag[0];
        end else begin
          r.status = ST_NOT_DUE;
        end
      end
      OP_RELEASE: begin
        if (m_fill == 0) begin
          r.status = ST_REL_EMPTY;
        end else begin
          for (int k = 1; k < m_fill; k++) begin
            m_ts[k-1] = m_ts[k]; m_arr[k-1] = m_arr[k];
            m_fr[k-1] = m_fr[k]; m_tag[k-1] = m_tag[k];
          end
          m_fill--;
          r.status = ST_RELEASED;
        end
      end
      default: begin
        m_fill = 0; m_und = '0; m_ovr = '0;
        r.status = ST_FLUSHED;
      end
    endcase
    r.fill = DEPTH_W'(m_fill);
    r.target = DEPTH_W'(m_target);
    r.und = m_und;
    r.ovr = m_ovr;
    awaited_results.push_back(r);
  endtask

  // Accept, check and timeout at the rising edge
  always @(posedge clk_i) begin
    buf_result_t e;
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      word_taken = in_valid_i && !in_stall_o && rst_ni;
      if (word_taken)
        buffer_step('{op: op_e'(op_i), ts: pkt_timestamp_i, arrival: arrival_ns_i,
                      frames: frame_count_i, tag: payload_tag_i, now: now_ns_i});
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word, status %0d", status_o);
        end else begin
          e = awaited_results[0];
          awaited_results.delete(0);
          if (status_o !== e.status || head_timestamp_o !== e.hts ||
              head_frames_o !== e.hfr || head_tag_o !== e.htag ||
              fill_level_o !== e.fill || target_level_o !== e.target ||
              underrun_total_o !== e.und || overrun_total_o !== e.ovr) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp st=%0d ts=%h fr=%0d tag=%h fill=%0d tgt=%0d u=%0d o=%0d",
                       e.status, e.hts, e.hfr, e.htag, e.fill, e.target, e.und, e.ovr);
              $display("         got st=%0d ts=%h fr=%0d tag=%h fill=%0d tgt=%0d u=%0d o=%0d",
                       status_o, head_timestamp_o, head_frames_o, head_tag_o,
                       fill_level_o, target_level_o, underrun_total_o, overrun_total_o);
            end
          end
        end
      end
    end
  end

  // Word driver: bursts with gaps, held while stalled
  always @(negedge clk_i) begin
    pkt_word_t w;
    if (rst_ni && (!in_valid_i || word_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        w = pending_words[0];
        pending_words.delete(0);
        op_i <= w.op;
        pkt_timestamp_i <= w.ts;
        arrival_ns_i <= w.arrival;
        frame_count_i <= w.frames;
        payload_tag_i <= w.tag;
        now_ns_i <= w.now;
        in_valid_i <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 7) == 0) send_mode = $urandom_range(0, 2);
          gap_left = (send_mode == 0) ? 0 : $urandom_range(0, send_mode * 5);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result stall pattern: quiet, light and heavy stretches
  always @(negedge clk_i) begin
    if (stall_timer == 0) begin
      stall_timer = $urandom_range(50, 400);
      stall_mode = $urandom_range(0, 2);
    end else begin
      stall_timer--;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 9) < 3);
      default: out_stall_i <= ($urandom_range(0, 9) < 8);
    endcase
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_MIN_DEPTH:   m_min = val[DEPTH_W-1:0];
      CFG_MAX_DEPTH:   m_max = val[DEPTH_W-1:0];
      CFG_SAMPLE_RATE: m_rate = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid_i || awaited_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic pkt_word_t make_word(op_e op, logic [TS_W-1:0] ts,
                                          logic [NS_W-1:0] arr, logic [FR_W-1:0] fr,
                                          logic [TAG_W-1:0] tag, logic [NS_W-1:0] now);
    return '{op: op, ts: ts, arrival: arr, frames: fr, tag: tag, now: now};
  endfunction

  // Random traffic around a common time base so polls land both sides of due
  task automatic queue_random(int count, logic [NS_W-1:0] base);
    int pick;
    op_e op;
    logic [NS_W-1:0] arr, now;
    logic [TS_W-1:0] ts;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      op = (pick < 42) ? OP_INSERT : (pick < 75) ? OP_POLL :
           (pick < 97) ? OP_RELEASE : OP_FLUSH;
      ts = ($urandom_range(0, 3) == 0) ? $urandom : TS_W'($urandom_range(0, 40));
      arr = ($urandom_range(0, 15) == 0) ? {$urandom, $urandom}
                                         : base + $urandom_range(0, 50000000);
      now = ($urandom_range(0, 15) == 0) ? {$urandom, $urandom}
                                         : base + $urandom_range(0, 800000000);
      pending_words.push_back(make_word(op, ts, arr, FR_W'($urandom_range(0, 4096)),
                                        TAG_W'($urandom), now));
    end
  endtask

  initial begin
    logic [NS_W-1:0] top;
    top = '1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty cases, extremes, equal stamps, overflow of the delay
    pending_words.push_back(make_word(OP_POLL, '0, '0, '0, '0, '0));
    pending_words.push_back(make_word(OP_RELEASE, '0, '0, '0, '0, '0));
    pending_words.push_back(make_word(OP_INSERT, '1, top, 13'd4096, 8'hff, '0));
    pending_words.push_back(make_word(OP_POLL, '0, '0, '0, '0, top));
    pending_words.push_back(make_word(OP_INSERT, '0, '0, '0, 8'h00, '0));
    pending_words.push_back(make_word(OP_POLL, '0, '0, '0, '0, '0));
    pending_words.push_back(make_word(OP_INSERT, 32'd7, 64'd1000, 13'd480, 8'h5a, '0));
    pending_words.push_back(make_word(OP_INSERT, 32'd7, 64'd2000, 13'd96, 8'ha5, '0));
    pending_words.push_back(make_word(OP_RELEASE, '0, '0, '0, '0, '0));
    pending_words.push_back(make_word(OP_POLL, '0, '0, '0, '0, 64'd50000999));
    pending_words.push_back(make_word(OP_POLL, '0, '0, '0, '0, 64'd50001000));
    for (int i = 0; i < 9; i++)
      pending_words.push_back(make_word(OP_INSERT, 32'(i * 3), 64'(i), 13'(i), 8'(i), '0));
    pending_words.push_back(make_word(OP_FLUSH, '0, '0, '0, '0, '0));
    pending_words.push_back(make_word(OP_POLL, '0, '0, '0, '0, '0));
    pending_words.push_back(make_word(OP_INSERT, 32'h8000_0000, top - 5, 13'd4096, 8'h01, '0));
    pending_words.push_back(make_word(OP_POLL, '0, '0, '0, '0, top));
    queue_random(200, 64'd1000000);

    // Phases across register settings; each one starts from an idle block
    wait_idle();
    write_reg(CFG_MIN_DEPTH, 18'd0);
    write_reg(CFG_MAX_DEPTH, 18'd32);
    write_reg(CFG_SAMPLE_RATE, 18'd192000);
    queue_random(200, {$urandom, $urandom} >> 2);
    wait_idle();
    write_reg(CFG_MIN_DEPTH, 18'd32);
    write_reg(CFG_SAMPLE_RATE, 18'd8000);
    queue_random(180, 64'd0);
    wait_idle();
    write_reg(CFG_MIN_DEPTH, 18'd3);
    write_reg(CFG_MAX_DEPTH, 18'd1);
    write_reg(CFG_SAMPLE_RATE, 18'd44100);
    queue_random(150, 64'd5000000);
    wait_idle();
    write_reg(CFG_MAX_DEPTH, 18'd0);
    queue_random(60, 64'd5000000);
    wait_idle();
    write_reg(CFG_MIN_DEPTH, 18'd1);
    write_reg(CFG_MAX_DEPTH, 18'd5);
    write_reg(CFG_SAMPLE_RATE, 18'd0);
    queue_random(150, 64'd100);
    wait_idle();
    write_reg(CFG_MIN_DEPTH, 18'd5);
    write_reg(CFG_MAX_DEPTH, 18'd12);
    write_reg(CFG_SAMPLE_RATE, 18'd96000);
    queue_random(200, top - 64'd900000000);
    wait_idle();
    write_reg(CFG_MIN_DEPTH, 18'd2);
    write_reg(CFG_MAX_DEPTH, 18'd32);
    write_reg(CFG_SAMPLE_RATE, 18'd48000);
    queue_random(286, 64'd123456789);

    wait_idle();
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
